/* src/stack_allocator_with_marks_defines.svh */
// Assertion macros shared by the stack allocator RTL.
`ifndef STACK_ALLOCATOR_WITH_MARKS_DEFINES_SVH
`define STACK_ALLOCATOR_WITH_MARKS_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define SAM_ASSERT_IMP(name, a, b) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("stack allocator assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define SAM_ASSERT_NEXT(name, a, b) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("stack allocator assertion failed");
`else
`define SAM_ASSERT_IMP(name, a, b)
`define SAM_ASSERT_NEXT(name, a, b)
`endif
`endif

/* src/sam_pkg.sv */
// Types, codes and constants of the stack allocator with marks.
package sam_pkg;

    localparam int ADDR_BITS      = 32;
    localparam int MARK_DEPTH     = 16;
    localparam int MIN_ALIGN_LOG2 = 3;
    localparam int MAX_ALIGN_LOG2 = 12;

    localparam int DATA_BITS      = 32;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [DATA_BITS-1:0] BASE_RESET     = 32'h0000_0000;
    localparam logic [DATA_BITS-1:0] CAPACITY_RESET = 32'h0001_0000;

    // Addresses leave through a 32-bit field; keep only ADDR_BITS of them
    localparam logic [DATA_BITS-1:0] ADDR_MASK = (ADDR_BITS >= DATA_BITS) ?
        32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BASE     = 1'b0,
        CFG_CAPACITY = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_RECORD = 2'd1,
        ACT_UNWIND = 2'd2,
        ACT_RESET  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_ARG     = 3'd1,
        ST_NO_SPACE    = 3'd2,
        ST_MARKS_FULL  = 3'd3,
        ST_MARKS_EMPTY = 3'd4
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } mark_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mark_stat_t;

endpackage

/* src/sam_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/sam_alloc.sv */
// Allocate datapath: align the top address, check the fit, form the new used count.
module sam_alloc (
    input  logic [31:0]      base_address,
    input  logic [31:0]      region_capacity,
    input  logic [31:0]      used_bytes,
    input  logic [31:0]      request_size,
    input  logic [4:0]       align_log2,
    output sam_pkg::status_t alloc_status,
    output logic [31:0]      alloc_address,
    output logic [31:0]      alloc_used
);

    logic [32:0] current;
    logic [31:0] align_mask;
    logic [31:0] pad;
    logic [33:0] aligned;
    logic [32:0] total;
    logic [31:0] left;
    logic        bad_arg;

    always_comb
    begin
        current    = {1'b0, base_address} + {1'b0, used_bytes};
        align_mask = ~(32'hFFFF_FFFF << align_log2);
        // padding up to the next boundary is the negated low bits
        pad        = (~current[31:0] + 32'd1) & align_mask;
        aligned    = {1'b0, current} + {2'b00, pad};
        total      = {1'b0, request_size} + {1'b0, pad};
        left       = (used_bytes >= region_capacity) ? 32'd0 :
                     region_capacity - used_bytes;
        bad_arg    = (request_size == 32'd0) ||
                     (align_log2 < 5'(sam_pkg::MIN_ALIGN_LOG2)) ||
                     (align_log2 > 5'(sam_pkg::MAX_ALIGN_LOG2));

        if (bad_arg)
        begin
            alloc_status = sam_pkg::ST_BAD_ARG;
        end
        else if (total > {1'b0, left})
        begin
            alloc_status = sam_pkg::ST_NO_SPACE;
        end
        else
        begin
            alloc_status = sam_pkg::ST_OK;
        end

        alloc_address = aligned[31:0] & sam_pkg::ADDR_MASK;
        alloc_used    = used_bytes + total[31:0];
    end

endmodule

/* src/sam_marks.sv */
// Mark stack: newest mark in a register, older marks in a RAM read one ahead.
module sam_marks #(
    parameter int MARK_DEPTH = sam_pkg::MARK_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sam_pkg::mark_ctrl_t  ctrl,
    input  logic [31:0]          push_data,
    output logic [31:0]          top_data,
    output sam_pkg::mark_stat_t  stat
);

    localparam int CW = $clog2(MARK_DEPTH + 1);
    localparam int AW = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;

    logic [CW-1:0] count_reg, count_next;
    logic          top_sel_reg, top_sel_next;
    logic [31:0]   top_reg, top_next;
    logic [31:0]   rd_data;
    logic [31:0]   top_value;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic          wr_en;

    // After a pop the new top arrives on the RAM read port
    assign top_value  = top_sel_reg ? rd_data : top_reg;
    assign top_data   = top_value;
    assign stat.full  = (count_reg == CW'(MARK_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign cnt_m1     = count_reg - CW'(1);
    assign cnt_m2     = count_reg - CW'(2);
    assign wr_en      = ctrl.push && (count_reg != '0);

    sam_ram #(
        .WIDTH (32),
        .DEPTH (MARK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_m1[AW-1:0]),
        .wr_data (top_value),
        .rd_addr (cnt_m2[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        count_next   = count_reg;
        top_sel_next = 1'b0;
        top_next     = top_value;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.push)
        begin
            count_next = count_reg + CW'(1);
            top_next   = push_data;
        end
        else if (ctrl.pop)
        begin
            count_next   = cnt_m1;
            top_sel_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            top_sel_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            top_sel_reg <= top_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

endmodule

/* src/stack_allocator_with_marks.sv */
// Top level of the stack allocator with marks: hold stage, execute, result register.
//
//  channel | direction | transfer when          | payload
//  in      | input     | in_valid & in_ready    | action, request_size, align_log2
//  out     | output    | out_valid & out_ready  | status, block_address
//  cfg     | input     | cfg_write              | cfg_index, cfg_data
//
// One request per cycle while out is not stalled; each result goes through the hold stage, then the result register.
// The used count and mark stack update in the execute cycle, so the next
// request sees them at once; the mark RAM is read one entry ahead.
// Reset clears the used count, mark count and both stages; no clearing pass.
// When out is stalled the result register holds, the hold stage takes one more
// request, then in_ready drops.
`include "stack_allocator_with_marks_defines.svh"

module stack_allocator_with_marks #(
    parameter int MARK_DEPTH = sam_pkg::MARK_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [sam_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         action,
    input  logic [31:0]                        request_size,
    input  logic [4:0]                         align_log2,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0]                         status,
    output logic [31:0]                        block_address
);

    logic [31:0]         base_reg;
    logic [31:0]         cap_reg;
    logic [31:0]         used_reg, used_next;

    logic                hold_valid_reg;
    sam_pkg::action_t    hold_action_reg;
    logic [31:0]         hold_size_reg;
    logic [4:0]          hold_align_reg;

    logic                out_valid_reg;
    sam_pkg::status_t    status_reg, status_next;
    logic [31:0]         addr_reg, addr_next;

    logic                exec_fire;
    sam_pkg::status_t    alloc_status;
    logic [31:0]         alloc_address;
    logic [31:0]         alloc_used;
    sam_pkg::mark_ctrl_t mark_ctrl;
    sam_pkg::mark_stat_t mark_stat;
    logic [31:0]         mark_top;

    assign exec_fire     = hold_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready      = !hold_valid_reg || exec_fire;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign block_address = addr_reg;

    sam_alloc u_alloc (
        .base_address    (base_reg),
        .region_capacity (cap_reg),
        .used_bytes      (used_reg),
        .request_size    (hold_size_reg),
        .align_log2      (hold_align_reg),
        .alloc_status    (alloc_status),
        .alloc_address   (alloc_address),
        .alloc_used      (alloc_used)
    );

    sam_marks #(
        .MARK_DEPTH (MARK_DEPTH)
    ) u_marks (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mark_ctrl),
        .push_data (used_reg),
        .top_data  (mark_top),
        .stat      (mark_stat)
    );

    always_comb
    begin
        status_next     = sam_pkg::ST_OK;
        addr_next       = 32'd0;
        used_next       = used_reg;
        mark_ctrl.push  = 1'b0;
        mark_ctrl.pop   = 1'b0;
        mark_ctrl.clear = 1'b0;
        case (hold_action_reg)
            sam_pkg::ACT_ALLOC:
            begin
                status_next = alloc_status;
                if (alloc_status == sam_pkg::ST_OK)
                begin
                    addr_next = alloc_address;
                    used_next = alloc_used;
                end
            end
            sam_pkg::ACT_RECORD:
            begin
                if (mark_stat.full)
                begin
                    status_next = sam_pkg::ST_MARKS_FULL;
                end
                else
                begin
                    mark_ctrl.push = exec_fire;
                end
            end
            sam_pkg::ACT_UNWIND:
            begin
                if (mark_stat.empty)
                begin
                    status_next = sam_pkg::ST_MARKS_EMPTY;
                end
                else
                begin
                    mark_ctrl.pop = exec_fire;
                    used_next     = mark_top;
                end
            end
            default:
            begin
                mark_ctrl.clear = exec_fire;
                used_next       = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= sam_pkg::BASE_RESET;
            cap_reg        <= sam_pkg::CAPACITY_RESET;
            used_reg       <= 32'd0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    sam_pkg::CFG_BASE:     base_reg <= cfg_data;
                    sam_pkg::CFG_CAPACITY: cap_reg  <= cfg_data;
                    default:               ;
                endcase
            end
            if (in_ready)
            begin
                hold_valid_reg <= in_valid;
            end
            if (exec_fire)
            begin
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_action_reg <= sam_pkg::action_t'(action);
            hold_size_reg   <= request_size;
            hold_align_reg  <= align_log2;
        end
        if (exec_fire)
        begin
            status_reg <= status_next;
            addr_reg   <= addr_next;
        end
    end

    `SAM_ASSERT_IMP(a_fail_no_addr, out_valid_reg && (status_reg != sam_pkg::ST_OK), addr_reg == 32'd0)
    `SAM_ASSERT_NEXT(a_fail_keeps_used, exec_fire && (status_next != sam_pkg::ST_OK), used_reg == $past(used_reg))
    `SAM_ASSERT_IMP(a_ready_low_held, !in_ready, hold_valid_reg && out_valid_reg && !out_ready)

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the stack allocator with marks.
module testbench;
    import sam_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        status_t     code;
        logic [31:0] addr;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    cfg_index_t  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    action_t     action;
    logic [31:0] request_size;
    logic [4:0]  align_log2;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [31:0] block_address;

    // Predictor copy of the allocator state and region registers
    logic [31:0] pred_base;
    logic [31:0] pred_capacity;
    logic [31:0] pred_used;
    logic [31:0] pred_marks [MARK_DEPTH];
    int          pred_mark_count;

    alloc_result_t expected_results[$];

    int send_gap_pct;
    int sink_stall_pct;
    bit hold_off_req;
    int hold_off_left;
    int cycle_count;
    int mismatch_count;
    int requests_sent;
    int results_checked;
    int config_writes;
    int status_tally [5];

    stack_allocator_with_marks uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .request_size  (request_size),
        .align_log2    (align_log2),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .block_address (block_address)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_off_req)
        begin
            hold_off_left = HOLD_OFF_CYCLES;
            hold_off_req  = 1'b0;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected: status %0d address %h",
                       status, block_address);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (status !== want.code)
                begin
                    $error("status: expected %0d, got %0d", want.code, status);
                    mismatch_count++;
                end
                if (block_address !== want.addr)
                begin
                    $error("block_address: expected %h, got %h", want.addr, block_address);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic alloc_result_t predict_allocator_result(
        input action_t act, input logic [31:0] size, input logic [4:0] lg);
        alloc_result_t r;
        logic [63:0] align, current, aligned, total, left;
        r.code = ST_OK;
        r.addr = '0;
        case (act)
            ACT_ALLOC:
            begin
                if (size == 0 || lg < MIN_ALIGN_LOG2 || lg > MAX_ALIGN_LOG2)
                begin
                    r.code = ST_BAD_ARG;
                end
                else
                begin
                    align   = 64'd1 << lg;
                    current = {32'd0, pred_base} + {32'd0, pred_used};
                    aligned = (current + align - 64'd1) & ~(align - 64'd1);
                    total   = {32'd0, size} + (aligned - current);
                    left    = (pred_used >= pred_capacity) ? 64'd0 :
                              {32'd0, pred_capacity - pred_used};
                    if (total > left)
                    begin
                        r.code = ST_NO_SPACE;
                    end
                    else
                    begin
                        pred_used = pred_used + total[31:0];
                        r.addr    = aligned[31:0] & ADDR_MASK;
                    end
                end
            end
            ACT_RECORD:
            begin
                if (pred_mark_count >= MARK_DEPTH)
                begin
                    r.code = ST_MARKS_FULL;
                end
                else
                begin
                    pred_marks[pred_mark_count] = pred_used;
                    pred_mark_count++;
                end
            end
            ACT_UNWIND:
            begin
                if (pred_mark_count == 0)
                begin
                    r.code = ST_MARKS_EMPTY;
                end
                else
                begin
                    pred_mark_count--;
                    pred_used = pred_marks[pred_mark_count];
                end
            end
            default:
            begin
                pred_used       = '0;
                pred_mark_count = 0;
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input action_t act, input logic [31:0] size,
                                input logic [4:0] lg);
        alloc_result_t want;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        request_size <= size;
        align_log2   <= lg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = predict_allocator_result(act, size, lg);
        expected_results.push_back(want);
        status_tally[want.code]++;
        requests_sent++;
    endtask

    // Drop valid and let every pending result drain out
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_region(input logic [31:0] base, input logic [31:0] cap);
        settle_idle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= CFG_CAPACITY;
        cfg_data  <= cap;
        @(posedge clk);
        cfg_write     <= 1'b0;
        pred_base     = base;
        pred_capacity = cap;
        config_writes += 2;
    endtask

    task automatic send_random_request();
        int pick;
        logic [31:0] size;
        logic [4:0]  lg;
        pick = $urandom_range(99);
        lg   = 5'($urandom_range(MAX_ALIGN_LOG2, MIN_ALIGN_LOG2));
        case ($urandom_range(9))
            0:       size = $urandom;
            1, 2:    size = $urandom_range(4096, 1);
            default: size = $urandom_range(256, 1);
        endcase
        if (pick < 55)
            send_request(ACT_ALLOC, size, lg);
        else if (pick < 70)
            send_request(ACT_RECORD, $urandom, 5'($urandom));
        else if (pick < 84)
            send_request(ACT_UNWIND, $urandom, 5'($urandom));
        else if (pick < 88)
            send_request(ACT_RESET, $urandom, 5'($urandom));
        else if (pick < 93)
            send_request(ACT_ALLOC, 32'd0, 5'($urandom));
        else
            send_request(ACT_ALLOC, $urandom, 5'($urandom));
    endtask

    task automatic test_directed();
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        send_request(ACT_ALLOC, 32'd0, 5'd3);
        send_request(ACT_ALLOC, 32'd8, 5'd2);
        send_request(ACT_ALLOC, 32'd8, 5'd13);
        send_request(ACT_ALLOC, 32'hFFFF_FFFF, 5'd31);
        send_request(ACT_ALLOC, 32'hFFFF_FFFF, 5'd12);
        send_request(ACT_UNWIND, 32'd0, 5'd0);
        send_request(ACT_ALLOC, 32'd1, 5'd3);
        send_request(ACT_ALLOC, 32'd1, 5'd12);
        send_request(ACT_ALLOC, 32'd65536, 5'd3);
        // Fill the mark stack, then one record too many
        repeat (MARK_DEPTH + 1) send_request(ACT_RECORD, 32'd0, 5'd0);
        send_request(ACT_UNWIND, 32'd0, 5'd0);
        // Exact fit of what is left, then no room at all
        send_request(ACT_ALLOC, 32'd61432, 5'd3);
        send_request(ACT_ALLOC, 32'd1, 5'd3);
        send_request(ACT_RESET, 32'd0, 5'd0);
        send_request(ACT_ALLOC, 32'd65536, 5'd3);
    endtask

    task automatic test_region_extremes();
        // Full-size region starting just below the top of the address space
        set_region(32'hFFFF_FFF8, 32'hFFFF_FFFF);
        send_request(ACT_RESET, 32'd0, 5'd0);
        send_request(ACT_ALLOC, 32'hFFFF_FFFF, 5'd3);
        send_request(ACT_ALLOC, 32'd1, 5'd3);
        // Region that wraps past the address width
        set_region(32'hFFFF_F000, 32'h0001_0000);
        send_request(ACT_RESET, 32'd0, 5'd0);
        send_request(ACT_ALLOC, 32'h0000_2000, 5'd12);
        send_request(ACT_ALLOC, 32'd16, 5'd12);
        // Smallest region
        set_region(32'h0000_1000, 32'd1);
        send_request(ACT_RESET, 32'd0, 5'd0);
        send_request(ACT_ALLOC, 32'd2, 5'd3);
        send_request(ACT_ALLOC, 32'd1, 5'd3);
        send_request(ACT_ALLOC, 32'd1, 5'd3);
        // Unaligned base forces padding
        set_region(32'h1234_5677, 32'h0001_0000);
        send_request(ACT_RESET, 32'd0, 5'd0);
        send_request(ACT_ALLOC, 32'd5, 5'd4);
        send_request(ACT_ALLOC, 32'd5, 5'd12);
        // Lower the capacity under the used count
        set_region(32'd0, 32'd65536);
        send_request(ACT_RESET, 32'd0, 5'd0);
        send_request(ACT_ALLOC, 32'd40000, 5'd3);
        send_request(ACT_RECORD, 32'd0, 5'd0);
        set_region(32'd0, 32'd100);
        send_request(ACT_ALLOC, 32'd1, 5'd3);
        send_request(ACT_UNWIND, 32'd0, 5'd0);
        send_request(ACT_ALLOC, 32'd1, 5'd3);
        send_request(ACT_RESET, 32'd0, 5'd0);
        send_request(ACT_ALLOC, 32'd50, 5'd3);
    endtask

    task automatic test_random_traffic(input int count, input int gap_pct,
                                       input int stall_pct);
        send_gap_pct   = gap_pct;
        sink_stall_pct = stall_pct;
        repeat (count) send_random_request();
    endtask

    task automatic test_output_backpressure();
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        hold_off_req   = 1'b1;
        repeat (40) send_random_request();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= CFG_BASE;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        action       <= ACT_ALLOC;
        request_size <= '0;
        align_log2   <= '0;
        out_ready    <= 1'b0;
        pred_base       = BASE_RESET;
        pred_capacity   = CAPACITY_RESET;
        pred_used       = '0;
        pred_mark_count = 0;
        send_gap_pct    = 0;
        sink_stall_pct  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_region_extremes();
        set_region(32'h0001_0000, 32'd65536);
        test_random_traffic(400, 12, 57);
        set_region($urandom & 32'hFFFF_F000, $urandom_range(1 << 20, 1));
        test_random_traffic(400, 57, 12);
        set_region($urandom, $urandom_range(300000, 4096));
        test_random_traffic(400, 0, 0);
        test_output_backpressure();
        settle_idle();

        $display("Covered %0d requests and %0d checked results across %0d register writes",
                 requests_sent, results_checked, config_writes);
        $display("Outcomes: ok %0d, bad argument %0d, no space %0d, marks full %0d, empty %0d",
                 status_tally[ST_OK], status_tally[ST_BAD_ARG], status_tally[ST_NO_SPACE],
                 status_tally[ST_MARKS_FULL], status_tally[ST_MARKS_EMPTY]);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
